[sv/tccs_pkg.sv]
// shared types, constants and the cell address helper of the text console cursor and scroll unit
package tccs_pkg;

	localparam int SCREEN_COLUMNS = 80;
	localparam int SCREEN_ROWS    = 25;
	localparam int CELL_COUNT     = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int ADDR_W         = $clog2(CELL_COUNT);
	localparam int ROW_W          = 5;
	localparam int COL_W          = 7;
	localparam int CHAR_W         = 8;
	localparam int CELL_W         = 16;
	localparam int BLANK_START    = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

	localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_TAB       = 8'd9;
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CODE_SPACE     = 8'h20;
	localparam logic [CHAR_W-1:0] RESET_COLOR    = 8'h0f;
	localparam int                TAB_STEP       = 8;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [CHAR_W-1:0]   char_code;
		logic [ROW_W-1:0]    read_row;
		logic [COL_W-1:0]    read_column;
	} request_t;

	typedef struct packed {
		logic [CELL_W-1:0]   cell_value;
		logic [ROW_W-1:0]    cursor_row;
		logic [COL_W-1:0]    cursor_column;
		logic                scrolled;
	} result_t;

	typedef struct packed {
		kind_t               kind;
		logic                scroll;
		logic [ADDR_W-1:0]   addr;
		logic [CELL_W-1:0]   data;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
	} cmd_t;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		cell_addr = ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

[sv/tccs_front.sv]
// front end: accepts items, tracks the cursor and turns each item into a memory command
module tccs_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  tccs_pkg::request_t      request,
	input  logic [7:0]              text_color,
	input  logic                    init_done,
	input  logic                    cmd_full,
	output logic                    cmd_push,
	output tccs_pkg::cmd_t          cmd
);

	localparam int RW = tccs_pkg::ROW_W;
	localparam int CW = tccs_pkg::COL_W;

	logic [RW-1:0]                row_q;
	logic [CW-1:0]                col_q;
	logic [RW:0]                  row_inc;
	logic [CW:0]                  col_inc;
	logic [CW:0]                  tab_sum;
	logic [RW:0]                  row_nx;
	logic [CW-1:0]                col_nx;
	logic                         scroll;
	logic [RW-1:0]                row_fin;
	tccs_pkg::kind_t              cmd_kind;
	logic [tccs_pkg::ADDR_W-1:0]  cmd_addr;
	logic [tccs_pkg::CELL_W-1:0]  cmd_data;

	assign full     = !init_done || cmd_full;
	assign cmd_push = push && !full;

	assign row_inc = {1'b0, row_q} + (RW+1)'(1);
	assign col_inc = {1'b0, col_q} + (CW+1)'(1);
	assign tab_sum = {1'b0, col_q} + (CW+1)'(tccs_pkg::TAB_STEP);

	always_comb begin
		row_nx   = {1'b0, row_q};
		col_nx   = col_q;
		cmd_kind = tccs_pkg::KIND_NONE;
		cmd_addr = tccs_pkg::cell_addr(row_q, col_q);
		cmd_data = {text_color, tccs_pkg::CODE_SPACE};
		unique case (request.opcode)
			tccs_pkg::OP_PUT: begin
				unique case (request.char_code)
					tccs_pkg::CODE_NEWLINE: begin
						col_nx = '0;
						row_nx = row_inc;
					end
					tccs_pkg::CODE_TAB: begin
						if (tab_sum >= (CW+1)'(tccs_pkg::SCREEN_COLUMNS)) begin
							col_nx = CW'(tab_sum - (CW+1)'(tccs_pkg::SCREEN_COLUMNS));
						end else begin
							col_nx = tab_sum[CW-1:0];
						end
					end
					tccs_pkg::CODE_BACKSPACE: begin
						if (col_q != '0) begin
							col_nx   = col_q - CW'(1);
							cmd_kind = tccs_pkg::KIND_WRITE;
							cmd_addr = tccs_pkg::cell_addr(row_q, col_q - CW'(1));
						end
					end
					default: begin
						cmd_kind = tccs_pkg::KIND_WRITE;
						cmd_data = {text_color, request.char_code};
						if (col_inc == (CW+1)'(tccs_pkg::SCREEN_COLUMNS)) begin
							col_nx = '0;
							row_nx = row_inc;
						end else begin
							col_nx = col_inc[CW-1:0];
						end
					end
				endcase
			end
			tccs_pkg::OP_CLEAR: begin
				cmd_kind = tccs_pkg::KIND_CLEAR;
				row_nx   = '0;
				col_nx   = '0;
			end
			tccs_pkg::OP_READ: begin
				cmd_addr = tccs_pkg::cell_addr(request.read_row, request.read_column);
				if (request.read_row < RW'(tccs_pkg::SCREEN_ROWS)
						&& request.read_column < CW'(tccs_pkg::SCREEN_COLUMNS)) begin
					cmd_kind = tccs_pkg::KIND_READ;
				end
			end
			default: begin
			end
		endcase
	end

	assign scroll  = (row_nx >= (RW+1)'(tccs_pkg::SCREEN_ROWS));
	assign row_fin = scroll ? RW'(tccs_pkg::SCREEN_ROWS - 1) : row_nx[RW-1:0];

	assign cmd = '{kind: cmd_kind, scroll: scroll, addr: cmd_addr, data: cmd_data,
		row: row_fin, col: col_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (cmd_push) begin
			row_q <= row_fin;
			col_q <= col_nx;
		end
	end

endmodule

[sv/tccs_cmd_q.sv]
// two-entry command queue between the front end and the back end
module tccs_cmd_q (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tccs_pkg::cmd_t  push_cmd,
	output logic            full,
	input  logic            pop,
	output tccs_pkg::cmd_t  head,
	output logic            empty
);

	tccs_pkg::cmd_t mem_q [2];
	logic           wptr_q;
	logic           rptr_q;
	logic [1:0]     count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

[sv/tccs_back.sv]
// back end: screen memory, scroll and clear sweeps, and the result queue
module tccs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         text_color,
	input  logic               cmd_empty,
	input  tccs_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               init_done,
	output logic               empty,
	input  logic               pop,
	output tccs_pkg::result_t  result
);

	localparam int AW = tccs_pkg::ADDR_W;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RD    = 4'b0010,
		ST_PRIME = 4'b0100,
		ST_SWEEP = 4'b1000
	} state_t;

	state_t                           state_q;
	state_t                           state_nx;
	logic [tccs_pkg::CELL_W-1:0]      mem [tccs_pkg::CELL_COUNT];
	logic [tccs_pkg::CELL_W-1:0]      rd_data_q;
	logic [AW-1:0]                    wr_idx_q;
	logic [AW-1:0]                    blank_start_q;
	logic [AW-1:0]                    blank_start_nx;
	logic                             init_q;
	logic                             init_done_q;
	tccs_pkg::result_t                hold_q;
	logic                             hold_load;
	tccs_pkg::result_t                res_now;

	logic                             mem_we;
	logic [AW-1:0]                    mem_waddr;
	logic [tccs_pkg::CELL_W-1:0]      mem_wdata;
	logic                             mem_re;
	logic [AW-1:0]                    mem_raddr;
	logic [AW:0]                      ahead;
	logic [tccs_pkg::CELL_W-1:0]      blank_cell;

	tccs_pkg::result_t                out_q [2];
	logic                             out_wptr_q;
	logic                             out_rptr_q;
	logic [1:0]                       out_count_q;
	logic                             out_push;
	logic                             out_pop;
	tccs_pkg::result_t                out_item;

	assign init_done  = init_done_q;
	assign empty      = (out_count_q == 2'd0);
	assign result     = out_q[out_rptr_q];
	assign out_pop    = pop && !empty;
	assign cmd_pop    = (state_q == ST_IDLE) && !cmd_empty && (out_count_q != 2'd2);
	assign blank_cell = {(init_q ? tccs_pkg::RESET_COLOR : text_color), tccs_pkg::CODE_SPACE};
	assign ahead      = {1'b0, wr_idx_q} + (AW+1)'(tccs_pkg::SCREEN_COLUMNS + 1);

	assign res_now.cell_value    = '0;
	assign res_now.cursor_row    = cmd.row;
	assign res_now.cursor_column = cmd.col;
	assign res_now.scrolled      = cmd.scroll;

	always_comb begin
		state_nx       = state_q;
		blank_start_nx = blank_start_q;
		hold_load      = 1'b0;
		mem_we         = 1'b0;
		mem_waddr      = cmd.addr;
		mem_wdata      = cmd.data;
		mem_re         = 1'b0;
		mem_raddr      = cmd.addr;
		out_push       = 1'b0;
		out_item       = res_now;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_pop) begin
					mem_we = (cmd.kind == tccs_pkg::KIND_WRITE);
					if (cmd.kind == tccs_pkg::KIND_CLEAR) begin
						hold_load      = 1'b1;
						blank_start_nx = '0;
						state_nx       = ST_PRIME;
					end else if (cmd.scroll) begin
						hold_load      = 1'b1;
						blank_start_nx = AW'(tccs_pkg::BLANK_START);
						state_nx       = ST_PRIME;
					end else if (cmd.kind == tccs_pkg::KIND_READ) begin
						hold_load = 1'b1;
						mem_re    = 1'b1;
						state_nx  = ST_RD;
					end else begin
						out_push = 1'b1;
					end
				end
			end
			ST_RD: begin
				out_push            = 1'b1;
				out_item            = hold_q;
				out_item.cell_value = rd_data_q;
				state_nx            = ST_IDLE;
			end
			ST_PRIME: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(tccs_pkg::SCREEN_COLUMNS);
				state_nx  = ST_SWEEP;
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = wr_idx_q;
				mem_wdata = (wr_idx_q < blank_start_q) ? rd_data_q : blank_cell;
				mem_re    = (ahead < (AW+1)'(tccs_pkg::CELL_COUNT));
				mem_raddr = ahead[AW-1:0];
				if (wr_idx_q == AW'(tccs_pkg::CELL_COUNT - 1)) begin
					state_nx = ST_IDLE;
					out_push = !init_q;
					out_item = hold_q;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
		if (hold_load) begin
			hold_q <= res_now;
		end
		if (out_push) begin
			out_q[out_wptr_q] <= out_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_PRIME;
			blank_start_q <= '0;
			wr_idx_q      <= '0;
			init_q        <= 1'b1;
			init_done_q   <= 1'b0;
			out_wptr_q    <= 1'b0;
			out_rptr_q    <= 1'b0;
			out_count_q   <= '0;
		end else begin
			state_q       <= state_nx;
			blank_start_q <= blank_start_nx;
			if (state_q == ST_PRIME) begin
				wr_idx_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				wr_idx_q <= wr_idx_q + AW'(1);
			end
			if (state_q == ST_SWEEP && state_nx == ST_IDLE && init_q) begin
				init_q      <= 1'b0;
				init_done_q <= 1'b1;
			end
			if (out_push) begin
				out_wptr_q <= !out_wptr_q;
			end
			if (out_pop) begin
				out_rptr_q <= !out_rptr_q;
			end
			out_count_q <= out_count_q + 2'(out_push) - 2'(out_pop);
		end
	end

endmodule

[sv/text_console_cursor_scroll_unit.sv]
// top level of the text console cursor and scroll unit
//
// request side: an item is taken when push is high and full is low; opcode
// selects put character, clear screen, read one cell or no operation
// result side: while empty is low the oldest result sits on result and
// leaves when pop is high; every item yields exactly one result
// cfg side: cfg_data is the text color, written when cfg_valid and
// cfg_ready are both high; cfg_ready is always high
// path: each item's command is registered in the command queue and its
// result in the result queue; a read also waits in ST_RD for the cell memory,
// which has one write port and one read port with registered read data
// scroll and clear run a sweep over the whole cell memory, one cell per
// cycle, after a priming read (ST_PRIME, then ST_SWEEP)
// sustained rate: one put without scroll per cycle while the result queue
// has room; reads do not overlap, as the single back-end sequencer waits in ST_RD
// reset: the cursor goes home and a clearing pass writes blank cells with
// color 0x0f over the memory; full stays high until that pass ends
// when the receiver stalls, two results queue up, then two commands, then
// full rises
module text_console_cursor_scroll_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tccs_pkg::request_t request,
	output logic               empty,
	input  logic               pop,
	output tccs_pkg::result_t  result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	logic [7:0]      text_color_q;
	logic            init_done;
	logic            cmd_full;
	logic            cmd_empty;
	logic            cmd_push;
	logic            cmd_pop;
	tccs_pkg::cmd_t  front_cmd;
	tccs_pkg::cmd_t  head_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tccs_pkg::RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	tccs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.request    (request),
		.text_color (text_color_q),
		.init_done  (init_done),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd        (front_cmd)
	);

	tccs_cmd_q u_cmd_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (front_cmd),
		.full     (cmd_full),
		.pop      (cmd_pop),
		.head     (head_cmd),
		.empty    (cmd_empty)
	);

	tccs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_color (text_color_q),
		.cmd_empty  (cmd_empty),
		.cmd        (head_cmd),
		.cmd_pop    (cmd_pop),
		.init_done  (init_done),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

[sv/tccs_checker.sv]
// port-level checks of the text console cursor and scroll unit, bound to the top level
module tccs_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  logic               pop,
	input  tccs_pkg::result_t  result
);

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.cursor_row < 5'(tccs_pkg::SCREEN_ROWS))
		else $error("cursor row beyond screen");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.cursor_column < 7'(tccs_pkg::SCREEN_COLUMNS))
		else $error("cursor column beyond screen");

	a_scroll_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.scrolled |-> result.cursor_row == 5'(tccs_pkg::SCREEN_ROWS - 1))
		else $error("scroll without cursor on last row");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting item changed or vanished");

endmodule

bind text_console_cursor_scroll_unit tccs_checker u_tccs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

[tb/tb_top.sv]
// testbench for the text console cursor and scroll unit: directed and random items checked against a local screen model
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tccs_pkg::*;

	localparam int SWEEP_CYCLES = CELL_COUNT + 100;
	localparam int TAIL_CYCLES  = 100;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int PRINT_LIMIT  = 40;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     push = 1'b0;
	logic     full;
	request_t request = '0;
	logic     empty;
	logic     pop = 1'b0;
	result_t  result;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	logic [CELL_W-1:0] screen_model [CELL_COUNT];
	logic [7:0]        text_color_q = RESET_COLOR;
	int                cur_row = 0;
	int                cur_col = 0;
	result_t           op_outcomes [$];

	int          send_idle_pct = 0;
	int          stall_pct = 0;
	int unsigned hold_left = 0;
	int          err_count = 0;
	int          cycle_count = 0;

	text_console_cursor_scroll_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	task automatic report_mismatch(input string what);
		if (err_count < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
		err_count++;
	endtask

	function automatic logic [CELL_W-1:0] blank_cell();
		return {text_color_q, CODE_SPACE};
	endfunction

	function automatic void blank_screen();
		for (int i = 0; i < CELL_COUNT; i++)
			screen_model[i] = blank_cell();
	endfunction

	function automatic result_t apply_console_op(input request_t req);
		result_t res;
		res = '0;
		case (req.opcode)
			OP_PUT: begin
				if (req.char_code == CODE_NEWLINE) begin
					cur_col = 0;
					cur_row++;
				end else if (req.char_code == CODE_TAB) begin
					cur_col = (cur_col + TAB_STEP) % SCREEN_COLUMNS;
				end else if (req.char_code == CODE_BACKSPACE) begin
					if (cur_col != 0) begin
						cur_col--;
						screen_model[cur_row * SCREEN_COLUMNS + cur_col] = blank_cell();
					end
				end else begin
					screen_model[cur_row * SCREEN_COLUMNS + cur_col] =
						{text_color_q, req.char_code};
					cur_col++;
					if (cur_col >= SCREEN_COLUMNS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= SCREEN_ROWS) begin
					for (int i = 0; i < BLANK_START; i++)
						screen_model[i] = screen_model[i + SCREEN_COLUMNS];
					for (int i = BLANK_START; i < CELL_COUNT; i++)
						screen_model[i] = blank_cell();
					cur_row = SCREEN_ROWS - 1;
					res.scrolled = 1'b1;
				end
			end
			OP_CLEAR: begin
				blank_screen();
				cur_row = 0;
				cur_col = 0;
			end
			OP_READ: begin
				if (int'(req.read_row) < SCREEN_ROWS && int'(req.read_column) < SCREEN_COLUMNS)
					res.cell_value =
						screen_model[int'(req.read_row) * SCREEN_COLUMNS + int'(req.read_column)];
			end
			default: begin
			end
		endcase
		res.cursor_row = ROW_W'(cur_row);
		res.cursor_column = COL_W'(cur_col);
		return res;
	endfunction

	// result side: check each popped item, then decide the next pop
	always @(posedge clk) begin : check_results
		result_t want;
		if (pop && empty === 1'b0) begin
			if (op_outcomes.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing outstanding", result));
			end else begin
				want = op_outcomes.pop_front();
				if (result.cell_value !== want.cell_value)
					report_mismatch($sformatf("cell_value got %h want %h",
						result.cell_value, want.cell_value));
				if (result.cursor_row !== want.cursor_row)
					report_mismatch($sformatf("cursor_row got %0d want %0d",
						result.cursor_row, want.cursor_row));
				if (result.cursor_column !== want.cursor_column)
					report_mismatch($sformatf("cursor_column got %0d want %0d",
						result.cursor_column, want.cursor_column));
				if (result.scrolled !== want.scrolled)
					report_mismatch($sformatf("scrolled got %b want %b",
						result.scrolled, want.scrolled));
			end
		end
		pop <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic request_t op_of(input opcode_t op, input logic [7:0] ch,
		input logic [4:0] r, input logic [6:0] c);
		request_t req;
		req.opcode = op;
		req.char_code = ch;
		req.read_row = r;
		req.read_column = c;
		return req;
	endfunction

	task automatic issue_op(input request_t req);
		push <= 1'b1;
		request <= req;
		do @(posedge clk); while (full !== 1'b0);
		op_outcomes.push_back(apply_console_op(req));
		while ($urandom_range(0, 99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic settle(input int extra);
		push <= 1'b0;
		while (op_outcomes.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic set_text_color(input logic [7:0] color);
		settle(SWEEP_CYCLES);
		cfg_valid <= 1'b1;
		cfg_data <= color;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		text_color_q = color;
	endtask

	task automatic test_reset_reads();
		issue_op(op_of(OP_READ, 8'h00, 5'd0, 7'd0));
		issue_op(op_of(OP_READ, 8'hff, 5'd24, 7'd79));
		issue_op(op_of(OP_READ, 8'h00, 5'd25, 7'd0));
		issue_op(op_of(OP_READ, 8'h00, 5'd0, 7'd80));
		issue_op(op_of(OP_READ, 8'h00, 5'd31, 7'd127));
	endtask

	task automatic test_put_and_backspace();
		issue_op(op_of(OP_PUT, 8'h41, 5'd0, 7'd0));
		issue_op(op_of(OP_PUT, 8'h00, 5'd31, 7'd127));
		issue_op(op_of(OP_PUT, 8'hff, 5'd0, 7'd0));
		issue_op(op_of(OP_PUT, CODE_BACKSPACE, 5'd0, 7'd0));
		issue_op(op_of(OP_READ, 8'h00, 5'd0, 7'd2));
		issue_op(op_of(OP_PUT, CODE_NEWLINE, 5'd0, 7'd0));
		issue_op(op_of(OP_PUT, CODE_BACKSPACE, 5'd0, 7'd0));
		issue_op(op_of(OP_NONE, 8'hff, 5'd31, 7'd127));
	endtask

	// ten tabs take the column past the row's end back to column 0
	task automatic test_tab_wrap();
		repeat (10) issue_op(op_of(OP_PUT, CODE_TAB, 5'd0, 7'd0));
	endtask

	task automatic test_clear();
		issue_op(op_of(OP_CLEAR, 8'h00, 5'd0, 7'd0));
		issue_op(op_of(OP_READ, 8'h00, 5'd1, 7'd0));
	endtask

	// receiver held off while a full screen of lines goes in and scrolls
	task automatic test_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		hold_left <= HOLD_CYCLES;
		for (int i = 0; i < 8; i++)
			issue_op(op_of(OP_PUT, 8'h61 + 8'(i), 5'd0, 7'd0));
		repeat (SCREEN_ROWS) issue_op(op_of(OP_PUT, CODE_NEWLINE, 5'd0, 7'd0));
		issue_op(op_of(OP_READ, 8'h00, 5'd24, 7'd0));
	endtask

	task automatic test_random_text(input int count, input int nl_pct,
		input int idle_pct, input int stall);
		request_t req;
		int pick;
		int sub;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			req.opcode = OP_PUT;
			req.char_code = 8'($urandom_range(0, 255));
			req.read_row = 5'($urandom_range(0, 31));
			req.read_column = 7'($urandom_range(0, 127));
			pick = $urandom_range(0, 999);
			if (pick < 2) begin
				req.opcode = OP_CLEAR;
			end else if (pick < 20) begin
				req.opcode = OP_NONE;
			end else if (pick < 220) begin
				req.opcode = OP_READ;
				if ($urandom_range(0, 99) < 80) begin
					req.read_row = 5'($urandom_range(0, SCREEN_ROWS - 1));
					req.read_column = 7'($urandom_range(0, SCREEN_COLUMNS - 1));
				end
			end else begin
				sub = $urandom_range(0, 99);
				if (sub < nl_pct)
					req.char_code = CODE_NEWLINE;
				else if (sub < nl_pct + 3)
					req.char_code = CODE_TAB;
				else if (sub < nl_pct + 7)
					req.char_code = CODE_BACKSPACE;
			end
			issue_op(req);
		end
	endtask

	initial begin
		blank_screen();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_reads();
		test_put_and_backspace();
		test_tab_wrap();
		test_clear();
		test_backpressure();
		set_text_color(8'h00);
		test_random_text(350, 1, 0, 0);
		set_text_color(8'hff);
		test_random_text(350, 5, 50, 0);
		set_text_color(8'($urandom_range(0, 255)));
		test_random_text(350, 5, 0, 50);
		set_text_color(8'($urandom_range(0, 255)));
		test_random_text(350, 3, 33, 33);
		stall_pct = 0;
		settle(TAIL_CYCLES);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
sv/tccs_pkg.sv
sv/tccs_front.sv
sv/tccs_cmd_q.sv
sv/tccs_back.sv
sv/text_console_cursor_scroll_unit.sv
sv/tccs_checker.sv
tb/tb_top.sv
